>>> rtl/lprt_pkg.sv
package lprt_pkg;

   localparam int TableEntries = 16;
   localparam int DeviceBits   = 4;
   localparam int IdxBits      = (TableEntries > 1) ? $clog2(TableEntries) : 1;

   localparam logic [31:0] BcastAddr = 32'hFFFF_FFFF;

   typedef logic [IdxBits-1:0]    idx_type;
   typedef logic [DeviceBits-1:0] dev_type;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_LOOKUP = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NO_DEVICE = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN_READ,
      ST_DRAIN_EVAL,
      ST_FINISH
   } state_type;

   // One stored route.
   typedef struct packed {
      logic [31:0] network;
      logic [31:0] mask;
      logic [31:0] gateway;
      dev_type     device;
      logic [31:0] order;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic    load_req;
      logic    rd_en;
      idx_type rd_addr;
      logic    finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } stat_type;

   // Count of leading ones in a mask.
   function automatic logic [5:0] leading_ones(logic [31:0] m);
      logic [5:0] n;
      n = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (!m[i]) begin
            n = 6'(31 - i);
         end
      end
      return n;
   endfunction

endpackage

>>> rtl/lprt_ctrl.sv
module lprt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lprt_pkg::stat_type stat,
   output lprt_pkg::cmd_type  cmd
);
   import lprt_pkg::*;

   state_type state_ff, state_in;
   idx_type   addr_ff, addr_in;
   logic      last_addr;

   assign last_addr = (addr_ff == IdxBits'(TableEntries - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_addr) begin
               state_in = ST_DRAIN_READ;
            end
         end
         ST_DRAIN_READ: state_in = ST_DRAIN_EVAL;
         ST_DRAIN_EVAL: state_in = ST_FINISH;
         ST_FINISH: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready    = 1'b0;
      cmd.load_req = 1'b0;
      cmd.rd_en    = 1'b0;
      cmd.rd_addr  = addr_ff;
      cmd.finish   = 1'b0;
      addr_in      = addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
            addr_in      = '0;
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            addr_in   = last_addr ? '0 : addr_ff + 1'b1;
         end
         ST_DRAIN_READ, ST_DRAIN_EVAL: begin
         end
         ST_FINISH: begin
            cmd.finish = stat.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

>>> rtl/lprt_dp.sv
module lprt_dp (
   input  logic               clock,
   input  logic               reset,
   input  lprt_pkg::cmd_type  cmd,
   output lprt_pkg::stat_type stat,
   input  logic [1:0]         req_action,
   input  logic [31:0]        req_dest_addr,
   input  logic [31:0]        req_net_mask,
   input  logic [31:0]        req_gateway_addr,
   input  lprt_pkg::dev_type  req_device_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output lprt_pkg::dev_type  rsp_out_device,
   output logic [31:0]        rsp_next_hop,
   output logic [5:0]         rsp_prefix_length
);
   import lprt_pkg::*;

   // Captured request.
   logic [1:0]  act_ff;
   logic [31:0] dst_ff, mask_ff, gw_ff;
   dev_type     dev_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff  <= req_action;
         dst_ff  <= req_dest_addr;
         mask_ff <= req_net_mask;
         gw_ff   <= req_gateway_addr;
         dev_ff  <= req_device_id;
      end
   end

   logic is_add, is_del, is_lkp;
   assign is_add = (act_ff == ACT_ADD);
   assign is_del = (act_ff == ACT_DELETE);
   assign is_lkp = (act_ff == ACT_LOOKUP);

   // Route memory and per-slot valid bits.
   entry_type              mem [TableEntries];
   entry_type              rd_data_ff;
   logic [TableEntries-1:0] valid_ff, valid_in;
   logic [31:0]            counter_ff, counter_in;
   logic                   wr_en, del_en;
   entry_type              wr_entry;

   // Scan pipeline.
   logic        s1_v_ff, s1_live_ff;
   idx_type     s1_idx_ff;
   logic        s2_v_ff, s2_live_ff, s2_match_ff;
   idx_type     s2_idx_ff;
   logic [5:0]  s2_len_ff;
   logic [31:0] s2_age_ff, s2_gw_ff;
   dev_type     s2_dev_ff;

   // Running choice.
   logic        found_ff, found_in;
   idx_type     best_idx_ff, best_idx_in;
   logic [5:0]  best_len_ff, best_len_in;
   logic [31:0] best_age_ff, best_age_in, best_gw_ff, best_gw_in;
   dev_type     best_dev_ff, best_dev_in;
   logic        free_found_ff, free_found_in;
   idx_type     free_idx_ff, free_idx_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, res_status;
   dev_type     rsp_dev_ff, res_dev;
   logic [31:0] rsp_nhop_ff, res_nhop;
   logic [5:0]  rsp_plen_ff, res_plen;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[free_idx_ff] <= wr_entry;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign wr_entry = '{network: dst_ff, mask: mask_ff, gateway: gw_ff,
                       device: dev_ff, order: counter_ff};
   assign wr_en  = cmd.finish && is_add && (dev_ff != '0) && free_found_ff;
   assign del_en = cmd.finish && is_del && found_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[free_idx_ff] = 1'b1;
      end
      if (del_en) begin
         valid_in[best_idx_ff] = 1'b0;
      end
      counter_in = wr_en ? counter_ff + 32'd1 : counter_ff;
   end

   // Stage 2 evaluation of the entry just read.
   logic        del_hit, lkp_hit, s2_match_in;
   logic [5:0]  s2_len_in;
   logic [31:0] s2_age_in;

   always_comb begin
      del_hit = (rd_data_ff.network == dst_ff)
             && ((mask_ff == '0) || (rd_data_ff.mask == mask_ff))
             && ((gw_ff == '0) || (rd_data_ff.gateway == gw_ff))
             && ((dev_ff == '0) || (rd_data_ff.device == dev_ff));
      lkp_hit = ((dst_ff & rd_data_ff.mask) == rd_data_ff.network)
             && ((dev_ff == '0) || (rd_data_ff.device == dev_ff));
      s2_match_in = s1_live_ff && ((is_del && del_hit) || (is_lkp && lkp_hit));
      s2_len_in   = leading_ones(rd_data_ff.mask);
      s2_age_in   = counter_ff - rd_data_ff.order;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         counter_ff   <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         counter_ff   <= counter_in;
         s1_v_ff      <= cmd.rd_en;
         s2_v_ff      <= s1_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff   <= cmd.rd_addr;
      s1_live_ff  <= valid_ff[cmd.rd_addr];
      s2_idx_ff   <= s1_idx_ff;
      s2_live_ff  <= s1_live_ff;
      s2_match_ff <= s2_match_in;
      s2_len_ff   <= s2_len_in;
      s2_age_ff   <= s2_age_in;
      s2_gw_ff    <= rd_data_ff.gateway;
      s2_dev_ff   <= rd_data_ff.device;
   end

   // Stage 3: fold the evaluated entry into the running choice.
   logic better;
   always_comb begin
      better = !found_ff
            || (is_lkp && (s2_len_ff > best_len_ff))
            || ((!is_lkp || (s2_len_ff == best_len_ff)) && (s2_age_ff > best_age_ff));
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_len_in   = best_len_ff;
      best_age_in   = best_age_ff;
      best_gw_in    = best_gw_ff;
      best_dev_in   = best_dev_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      if (cmd.load_req) begin
         found_in      = 1'b0;
         free_found_in = 1'b0;
      end else if (s2_v_ff) begin
         if (s2_match_ff && better) begin
            found_in    = 1'b1;
            best_idx_in = s2_idx_ff;
            best_len_in = s2_len_ff;
            best_age_in = s2_age_ff;
            best_gw_in  = s2_gw_ff;
            best_dev_in = s2_dev_ff;
         end
         if (!s2_live_ff && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = s2_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
      end
      best_idx_ff <= best_idx_in;
      best_len_ff <= best_len_in;
      best_age_ff <= best_age_in;
      best_gw_ff  <= best_gw_in;
      best_dev_ff <= best_dev_in;
      free_idx_ff <= free_idx_in;
   end

   // Result of the finished action.
   always_comb begin
      res_status = STAT_NOT_FOUND;
      res_dev    = '0;
      res_nhop   = '0;
      res_plen   = '0;
      unique case (act_ff)
         ACT_ADD: begin
            if (dev_ff == '0) begin
               res_status = STAT_NO_DEVICE;
            end else if (!free_found_ff) begin
               res_status = STAT_FULL;
            end else begin
               res_status = STAT_OK;
            end
         end
         ACT_DELETE: begin
            if (found_ff) begin
               res_status = STAT_OK;
            end
         end
         ACT_LOOKUP: begin
            if (dst_ff == BcastAddr) begin
               res_status = STAT_OK;
               res_nhop   = dst_ff;
            end else if (found_ff) begin
               res_status = STAT_OK;
               res_dev    = best_dev_ff;
               res_nhop   = (best_gw_ff != '0) ? best_gw_ff : dst_ff;
               res_plen   = best_len_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= res_status;
         rsp_dev_ff    <= res_dev;
         rsp_nhop_ff   <= res_nhop;
         rsp_plen_ff   <= res_plen;
      end
   end

   assign stat.out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_device    = rsp_dev_ff;
   assign rsp_next_hop      = rsp_nhop_ff;
   assign rsp_prefix_length = rsp_plen_ff;

endmodule

>>> rtl/longest_prefix_route_table.sv
// IPv4 longest-prefix route table with TableEntries slots (16). Each request beat carries one
// action: add a route into the lowest free slot, delete the earliest-inserted route that matches
// (zero mask, gateway or device act as wildcards), or look up an address, optionally restricted
// to one device, returning the longest-prefix match with ties going to the earliest-inserted
// route. Every request yields exactly one response beat. The table lives in a single-port-read
// memory that is scanned one entry per cycle. A request is accepted, every entry is read in turn,
// the evaluate and compare stages behind the memory drain, and the result is then committed and
// loaded into the response register. The request side is ready only between requests. A finished
// response sits in an output register; the next request can be accepted and scanned while it
// waits, and only the commit step holds off until the response register is free. No clearing
// pass is needed after reset.
module longest_prefix_route_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_dest_addr,
   input  logic [31:0] req_net_mask,
   input  logic [31:0] req_gateway_addr,
   input  logic [3:0]  req_device_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_out_device,
   output logic [31:0] rsp_next_hop,
   output logic [5:0]  rsp_prefix_length
);
   import lprt_pkg::*;

   // Commands flow from the controller into the datapath; the datapath only reports
   // whether the response register can take a new result.
   cmd_type  cmd;
   stat_type stat;

   lprt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the route memory, the valid bits, the insertion counter,
   // the scan pipeline and the response register.
   lprt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_action),
      .req_dest_addr     (req_dest_addr),
      .req_net_mask      (req_net_mask),
      .req_gateway_addr  (req_gateway_addr),
      .req_device_id     (req_device_id[DeviceBits-1:0]),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_out_device    (rsp_out_device),
      .rsp_next_hop      (rsp_next_hop),
      .rsp_prefix_length (rsp_prefix_length)
   );

endmodule

>>> rtl/lprt_checker.sv
module lprt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [3:0]  rsp_out_device,
   input logic [31:0] rsp_next_hop,
   input logic [5:0]  rsp_prefix_length
);
   import lprt_pkg::*;

   // A stalled response beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_device) && $stable(rsp_next_hop) && $stable(rsp_prefix_length))
      else $error("response changed while stalled");

   // A failed action reports all-zero route fields.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |->
         (rsp_out_device == '0) && (rsp_next_hop == '0) && (rsp_prefix_length == '0))
      else $error("failed action carries route fields");

   // Prefix length never exceeds the address width.
   a_plen_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_prefix_length <= 6'd32))
      else $error("prefix length out of range");

   // Only a real route hit has a device; without one there is no prefix.
   a_nodev_noplen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_OK) && (rsp_out_device == '0) |->
         (rsp_prefix_length == '0))
      else $error("prefix length without device");

   // The table works on one request at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind longest_prefix_route_table lprt_checker u_lprt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_out_device    (rsp_out_device),
   .rsp_next_hop      (rsp_next_hop),
   .rsp_prefix_length (rsp_prefix_length)
);
